// ----- rtl/hvf_pkg.sv -----
package hvf_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 28;
   localparam int KIND_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0]        GROUP_MORE   = 8'h80;
   localparam logic [7:0]        GROUP_BITS   = 8'h7F;

   typedef enum logic [2:0] {
      PHASE_WAIT  = 3'd0,
      PHASE_START = 3'd1,
      PHASE_CMD   = 3'd2,
      PHASE_COUNT = 3'd3,
      PHASE_ARGS  = 3'd4,
      PHASE_TEXT  = 3'd5
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_CMD   = 3'd0,
      KIND_COUNT = 3'd1,
      KIND_ARG   = 3'd2,
      KIND_TEXT  = 3'd3,
      KIND_ERROR = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [VALUE_W-1:0] value;
      logic               last;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] digit;
   } hex_type;

   function automatic hex_type hex_decode(input logic [CHAR_W-1:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.digit = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.digit = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         h.digit = c[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

// ----- rtl/hex_varint_frame_decoder.sv -----
// Hex varint frame decoder.
// req_* carries one ASCII character per item in req_tdata. Characters are
// dropped until a newline; after it, frames of hex-pair bytes are decoded
// into 7-bit-per-byte big-endian numbers (bit 7 set means more bytes follow).
// rsp_* carries one result item: rsp_tdata[2:0] kind (0 command, 1 count,
// 2 argument, 3 text character, 4 error), rsp_tdata[30:3] value, and
// rsp_tlast on the final item of a frame.
// Each result is registered in the output buffer before it shows on rsp_*.
// Throughput: one character per cycle while req_tready is high; the parse
// state updates in the same cycle the character is accepted, and a two-entry
// output register absorbs the result.
// Reset: the parser returns to waiting for a newline and the output buffer
// empties.
// Stall: while rsp_tready is low up to two results are held; req_tready then
// drops until the receiver takes one.
module hex_varint_frame_decoder #(
   parameter int MAX_GROUPS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [2:0] kind, [30:3] value, [31] zero
   output logic        rsp_tlast
);

   logic                accept;
   logic                res_valid;
   hvf_pkg::result_type res;
   hvf_pkg::result_type out_data;

   assign accept = req_tvalid && req_tready;

   hvf_parser #(
      .MAX_GROUPS(MAX_GROUPS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_in   (req_tdata),
      .res_valid (res_valid),
      .res       (res)
   );

   hvf_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_data)
   );

   assign rsp_tdata = {1'b0, out_data.value, out_data.kind};
   assign rsp_tlast = out_data.last;

endmodule

// ----- rtl/hvf_parser.sv -----
module hvf_parser #(
   parameter int MAX_GROUPS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [hvf_pkg::CHAR_W-1:0] char_in,
   output logic                      res_valid,
   output hvf_pkg::result_type       res
);

   localparam int GC_W = (MAX_GROUPS < 2) ? 1 : $clog2(MAX_GROUPS + 1);

   hvf_pkg::phase_type           phase_ff, phase_in;
   logic                         pending_ff, pending_in;
   logic [3:0]                   high_ff, high_in;
   logic [hvf_pkg::VALUE_W-1:0]  acc_ff, acc_in;
   logic [GC_W-1:0]              gc_ff, gc_in;
   logic [hvf_pkg::VALUE_W-1:0]  args_ff, args_in;

   hvf_pkg::hex_type             hex;
   hvf_pkg::phase_type           num_phase;
   logic                         is_nl;
   logic                         cur_pending;
   logic [hvf_pkg::VALUE_W-1:0]  cur_acc;
   logic [GC_W-1:0]              cur_gc;
   logic [GC_W-1:0]              gc_next;
   logic [7:0]                   byte_val;
   logic [hvf_pkg::VALUE_W-1:0]  acc_next;
   logic [hvf_pkg::VALUE_W-1:0]  args_dec;

   always_comb begin
      hex         = hvf_pkg::hex_decode(char_in);
      is_nl       = (char_in == hvf_pkg::NEWLINE_CHAR);
      num_phase   = (phase_ff == hvf_pkg::PHASE_START) ? hvf_pkg::PHASE_CMD : phase_ff;
      cur_pending = (phase_ff == hvf_pkg::PHASE_START) ? 1'b0 : pending_ff;
      cur_acc     = (phase_ff == hvf_pkg::PHASE_START) ? '0 : acc_ff;
      cur_gc      = (phase_ff == hvf_pkg::PHASE_START) ? '0 : gc_ff;
      byte_val    = {high_ff, hex.digit};
      acc_next    = {cur_acc[hvf_pkg::VALUE_W-8:0], byte_val[6:0] & hvf_pkg::GROUP_BITS[6:0]};
      gc_next     = cur_gc + 1'b1;
      args_dec    = args_ff - 1'b1;

      phase_in   = phase_ff;
      pending_in = pending_ff;
      high_in    = high_ff;
      acc_in     = acc_ff;
      gc_in      = gc_ff;
      args_in    = args_ff;
      res_valid  = 1'b0;
      res.kind   = hvf_pkg::KIND_ERROR;
      res.value  = '0;
      res.last   = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            hvf_pkg::PHASE_WAIT: begin
               if (is_nl) begin
                  phase_in = hvf_pkg::PHASE_START;
               end
            end
            hvf_pkg::PHASE_TEXT: begin
               res_valid = 1'b1;
               res.kind  = hvf_pkg::KIND_TEXT;
               res.value = hvf_pkg::VALUE_W'(char_in);
               res.last  = is_nl;
               if (is_nl) begin
                  phase_in = hvf_pkg::PHASE_START;
               end
            end
            hvf_pkg::PHASE_START, hvf_pkg::PHASE_CMD,
            hvf_pkg::PHASE_COUNT, hvf_pkg::PHASE_ARGS: begin
               if (is_nl && phase_ff == hvf_pkg::PHASE_START) begin
                  phase_in = phase_ff;
               end else if (is_nl || !hex.valid) begin
                  // drop the frame, resync on newline
                  res_valid  = 1'b1;
                  res.last   = 1'b1;
                  phase_in   = is_nl ? hvf_pkg::PHASE_START : hvf_pkg::PHASE_WAIT;
                  pending_in = 1'b0;
                  high_in    = '0;
                  acc_in     = '0;
                  gc_in      = '0;
                  args_in    = '0;
               end else if (!cur_pending) begin
                  phase_in   = num_phase;
                  pending_in = 1'b1;
                  high_in    = hex.digit;
                  acc_in     = cur_acc;
                  gc_in      = cur_gc;
               end else if ((byte_val & hvf_pkg::GROUP_MORE) != 8'h00) begin
                  pending_in = 1'b0;
                  high_in    = '0;
                  if (gc_next >= GC_W'(MAX_GROUPS)) begin
                     res_valid = 1'b1;
                     res.last  = 1'b1;
                     phase_in  = hvf_pkg::PHASE_WAIT;
                     acc_in    = '0;
                     gc_in     = '0;
                     args_in   = '0;
                  end else begin
                     acc_in = acc_next;
                     gc_in  = gc_next;
                  end
               end else begin
                  pending_in = 1'b0;
                  high_in    = '0;
                  acc_in     = '0;
                  gc_in      = '0;
                  res_valid  = 1'b1;
                  res.value  = acc_next;
                  unique case (num_phase)
                     hvf_pkg::PHASE_CMD: begin
                        res.kind = hvf_pkg::KIND_CMD;
                        phase_in = (acc_next == '0) ? hvf_pkg::PHASE_TEXT
                                                    : hvf_pkg::PHASE_COUNT;
                     end
                     hvf_pkg::PHASE_COUNT: begin
                        res.kind = hvf_pkg::KIND_COUNT;
                        if (acc_next == '0) begin
                           res.last = 1'b1;
                           phase_in = hvf_pkg::PHASE_WAIT;
                        end else begin
                           args_in  = acc_next;
                           phase_in = hvf_pkg::PHASE_ARGS;
                        end
                     end
                     default: begin
                        res.kind = hvf_pkg::KIND_ARG;
                        args_in  = args_dec;
                        if (args_dec == '0) begin
                           res.last = 1'b1;
                           phase_in = hvf_pkg::PHASE_WAIT;
                        end
                     end
                  endcase
               end
            end
            default: begin
               phase_in   = hvf_pkg::PHASE_WAIT;
               pending_in = 1'b0;
               high_in    = '0;
               acc_in     = '0;
               gc_in      = '0;
               args_in    = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= hvf_pkg::PHASE_WAIT;
         pending_ff <= 1'b0;
         high_ff    <= '0;
         acc_ff     <= '0;
         gc_ff      <= '0;
         args_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         high_ff    <= high_in;
         acc_ff     <= acc_in;
         gc_ff      <= gc_in;
         args_ff    <= args_in;
      end
   end

   a_error_ends_frame: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == hvf_pkg::KIND_ERROR |-> res.last && res.value == '0)
      else $error("error item must close the frame with zero value");

   a_wait_silent: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == hvf_pkg::PHASE_WAIT |-> !res_valid)
      else $error("item emitted while waiting for newline");

   a_text_echo: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == hvf_pkg::PHASE_TEXT |-> res_valid && res.kind == hvf_pkg::KIND_TEXT)
      else $error("text phase must echo each character");

   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      gc_ff < GC_W'(MAX_GROUPS))
      else $error("group count exceeded limit");

endmodule

// ----- rtl/hvf_out_buf.sv -----
module hvf_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hvf_pkg::result_type push_data,
   output logic                push_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output hvf_pkg::result_type out_data
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   hvf_pkg::result_type main_ff, main_in;
   hvf_pkg::result_type skid_ff, skid_in;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid holds an item while output is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("item pushed into full buffer");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> main_valid_ff && main_ff == $past(skid_ff))
      else $error("skid item lost on drain");

endmodule
